FILE: sv/obwb_pkg.sv
// Shared types and constants for the output write batch buffer.
package obwb_pkg;

    // action codes carried in tuser
    localparam logic [1:0] ACT_APPEND  = 2'd0;
    localparam logic [1:0] ACT_CONSUME = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;
    localparam logic [1:0] ACT_NOP     = 2'd3;

    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 272;
    localparam int unsigned HW_W       = 15;
    localparam int unsigned CNT_W      = 15;
    localparam int unsigned OFS_W      = 14;

    localparam logic [HW_W-1:0]  HIGH_WATER_RESET = 15'd12288;
    localparam logic [CNT_W-1:0] BATCH_MAX        = 15'd32767;

    // controller -> datapath
    typedef struct packed {
        logic exec;     // input word accepted this cycle
        logic rd_done;  // memory read data is valid this cycle
    } t_cmd;

endpackage

FILE: sv/obwb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module obwb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/obwb_ctrl.sv
// Controller: input/output handshake and read sequencing.
module obwb_ctrl import obwb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [1:0] s_axis_tuser,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output t_cmd       o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic acc, load;

    // a new word may enter while no read is in flight and the output slot is free or being emptied
    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign load          = (acc && (s_axis_tuser != ACT_READ)) || (r_state == S_READ);

    assign o_cmd.exec    = acc;
    assign o_cmd.rd_done = (r_state == S_READ);
    assign m_axis_tvalid = r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc && (s_axis_tuser == ACT_READ)) begin
                    n_state = S_READ;
                end
            end
            S_READ:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("read in flight while output slot occupied");

    a_read_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_out_valid && r_state == S_IDLE))
        else $error("read did not produce a result");

endmodule

FILE: sv/obwb_dp.sv
// Datapath: ring pointers, counters, byte store and result register.
module obwb_dp import obwb_pkg::*; #(
    parameter int unsigned CAPACITY = 16384
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [1:0]            i_action,
    input  logic                  i_call_last,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic                  i_cfg_we,
    input  logic [HW_W-1:0]       i_cfg_data,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    localparam int unsigned PW = $clog2(CAPACITY);
    localparam int unsigned LW = $clog2(CAPACITY + 1);
    localparam int unsigned CW = (LW > CNT_W) ? LW : CNT_W;
    localparam logic [PW:0]   CAP_P = (PW+1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [7:0]       data_byte;
    logic [CNT_W-1:0] consume_count;
    logic [OFS_W-1:0] read_offset;

    assign data_byte     = i_in_data[7:0];
    assign consume_count = i_in_data[22:8];
    assign read_offset   = i_in_data[36:23];

    logic [PW-1:0]    r_head, n_head;
    logic [LW-1:0]    r_length, n_length;
    logic             r_mid_call, n_mid_call;
    logic             r_reject, n_reject;
    logic [CNT_W-1:0] r_batch, n_batch;
    logic [63:0]      r_bytes, n_bytes;
    logic [63:0]      r_calls, n_calls;
    logic [63:0]      r_drains, n_drains;
    logic [31:0]      r_overflows, n_overflows;
    logic [HW_W-1:0]  r_high_water;
    logic             r_acc, r_rin;
    logic [7:0]       r_rdata;

    logic [CW-1:0] len_c, cnt_c, ofs_c;
    logic          has_room, in_range, empties;
    logic [PW:0]   wsum, csum, rsum;
    logic [PW-1:0] waddr, new_head, raddr;
    logic          we, re;
    logic [7:0]    ram_q;

    assign len_c    = CW'(r_length);
    assign cnt_c    = CW'(consume_count);
    assign ofs_c    = CW'(read_offset);
    assign has_room = len_c < CAP_C;
    assign in_range = ofs_c < len_c;
    assign empties  = cnt_c >= len_c;

    // ring positions: head below capacity, other term at most capacity, so one subtract wraps
    assign wsum     = {1'b0, r_head} + (PW+1)'(r_length);
    assign waddr    = (wsum >= CAP_P) ? PW'(wsum - CAP_P) : PW'(wsum);
    assign csum     = {1'b0, r_head} + {1'b0, cnt_c[PW-1:0]};
    assign new_head = (csum >= CAP_P) ? PW'(csum - CAP_P) : PW'(csum);
    assign rsum     = {1'b0, r_head} + {1'b0, ofs_c[PW-1:0]};
    assign raddr    = (rsum >= CAP_P) ? PW'(rsum - CAP_P) : PW'(rsum);

    assign we = i_cmd.exec && (i_action == ACT_APPEND) && has_room;
    assign re = i_cmd.exec && (i_action == ACT_READ) && in_range;

    obwb_ram #(
        .WIDTH (8),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (data_byte),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_head      = r_head;
        n_length    = r_length;
        n_mid_call  = r_mid_call;
        n_reject    = r_reject;
        n_batch     = r_batch;
        n_bytes     = r_bytes;
        n_calls     = r_calls;
        n_drains    = r_drains;
        n_overflows = r_overflows;
        case (i_action)
            ACT_APPEND: begin
                if (has_room) begin
                    n_length = r_length + LW'(1);
                    n_bytes  = r_bytes + 64'd1;
                    if (!r_mid_call) begin
                        if (r_batch != BATCH_MAX) begin
                            n_batch = r_batch + CNT_W'(1);
                        end
                        n_calls = r_calls + 64'd1;
                    end
                end else if (!r_reject) begin
                    n_overflows = r_overflows + 32'd1;
                    n_reject    = 1'b1;
                end
                n_mid_call = !i_call_last;
                if (i_call_last) begin
                    n_reject = 1'b0;
                end
            end
            ACT_CONSUME: begin
                if (empties) begin
                    n_length = '0;
                    n_head   = '0;
                    n_batch  = '0;
                end else begin
                    n_head   = new_head;
                    n_length = r_length - LW'(cnt_c);
                end
                n_drains = r_drains + 64'd1;
            end
            ACT_READ, ACT_NOP: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_length     <= '0;
            r_mid_call   <= 1'b0;
            r_reject     <= 1'b0;
            r_batch      <= '0;
            r_bytes      <= '0;
            r_calls      <= '0;
            r_drains     <= '0;
            r_overflows  <= '0;
            r_high_water <= HIGH_WATER_RESET;
        end else begin
            if (i_cmd.exec) begin
                r_head      <= n_head;
                r_length    <= n_length;
                r_mid_call  <= n_mid_call;
                r_reject    <= n_reject;
                r_batch     <= n_batch;
                r_bytes     <= n_bytes;
                r_calls     <= n_calls;
                r_drains    <= n_drains;
                r_overflows <= n_overflows;
            end
            if (i_cfg_we) begin
                r_high_water <= i_cfg_data;
            end
        end
    end

    // per-word result bits; counters are shown straight from state,
    // which holds while a result waits
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_acc   <= we;
            r_rin   <= re;
            r_rdata <= '0;
        end else if (i_cmd.rd_done) begin
            r_rdata <= r_rin ? ram_q : 8'd0;
        end
    end

    logic pressure, ready_res;
    assign pressure  = len_c >= CW'(r_high_water);
    assign ready_res = (r_length != '0);

    assign o_out_data = {6'd0, r_overflows, r_drains, r_calls, r_bytes, r_batch,
                         ready_res, pressure, len_c[CNT_W-1:0], r_rin, r_rdata, r_acc};

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        len_c <= CAP_C)
        else $error("pending length above capacity");

    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_length == '0) |-> (r_head == '0))
        else $error("empty buffer with nonzero head");

    a_reject_in_call: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_reject |-> r_mid_call)
        else $error("reject flag set outside a call");

endmodule

FILE: sv/output_write_batch_buffer_unit.sv
// Byte batch buffer: a ring of CAPACITY bytes fed by append words and emptied by consume
// words, with random-offset reads, a high-watermark pressure flag and lifetime counters.
// Every input word yields one result word. An append, consume or no-op result is registered
// for the next cycle; a read result passes the registered read port of the byte store, then
// the result register. A new word is taken when no read is in flight and the output register
// is empty or being emptied, so appends and consumes sustain one word per cycle while the
// output side keeps up. Byte store contents are not cleared at reset; only bytes inside the
// pending length are ever read. Configuration (high water) is taken every cycle.
module output_write_batch_buffer_unit import obwb_pkg::*; #(
    parameter int unsigned CAPACITY = 16384
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // data_byte[7:0], consume_count[22:8], read_offset[36:23], zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action[1:0]
    input  logic [1:0]            s_axis_tuser,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // accepted[0], read_data[8:1], read_in_range[9], pending_length[24:10],
    // pressure[25], ready_res[26], calls_since_drain[41:27], lifetime_bytes[105:42],
    // total_calls[169:106], drain_count[233:170], overflow_count[265:234], zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [HW_W-1:0]       i_cfg_data
);

    t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    obwb_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_cmd         (cmd)
    );

    obwb_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_action    (s_axis_tuser),
        .i_call_last (s_axis_tlast),
        .i_in_data   (s_axis_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (m_axis_tdata)
    );

endmodule

FILE: test/output_write_batch_buffer_unit_test.sv
// Self-checking testbench for the output write batch buffer unit.
module output_write_batch_buffer_unit_test;
    import obwb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 16384;
    localparam int RES_W = 266;

    typedef struct {
        logic [1:0]  action;
        logic [7:0]  byte_val;
        logic        last;
        logic [14:0] count;
        logic [13:0] offset;
    } buf_op_t;

    // same order as the result word, last field in the lowest bits
    typedef struct packed {
        logic [31:0] overflow_count;
        logic [63:0] drain_count;
        logic [63:0] total_calls;
        logic [63:0] lifetime_bytes;
        logic [14:0] calls_since_drain;
        logic        ready_res;
        logic        pressure;
        logic [14:0] pending_length;
        logic        read_in_range;
        logic [7:0]  read_data;
        logic        accepted;
    } buf_status_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [HW_W-1:0]       i_cfg_data;

    output_write_batch_buffer_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // buffer model state
    logic [7:0]  byte_mem [CAP];
    logic [13:0] head_ptr;
    logic [14:0] fill_len;
    logic        in_call;
    logic        call_dropped;
    logic [14:0] batch_calls;
    logic [63:0] bytes_sum;
    logic [63:0] calls_sum;
    logic [63:0] drains_sum;
    logic [31:0] overflow_sum;
    logic [14:0] hw_level;

    buf_status_t status_q[$];
    int          mismatches = 0;
    int          src_idle = 0;
    int          sink_stall = 0;

    function automatic buf_status_t predict_status(input buf_op_t op);
        buf_status_t r;
        logic [13:0] slot;
        r = '0;
        case (op.action)
            ACT_APPEND: begin
                if (fill_len < CAP) begin
                    slot = head_ptr + fill_len[13:0];
                    byte_mem[slot] = op.byte_val;
                    fill_len = fill_len + 15'd1;
                    bytes_sum = bytes_sum + 64'd1;
                    r.accepted = 1'b1;
                    // a call counts only when its first byte gets in
                    if (!in_call) begin
                        if (batch_calls < BATCH_MAX) batch_calls = batch_calls + 15'd1;
                        calls_sum = calls_sum + 64'd1;
                    end
                end else if (!call_dropped) begin
                    overflow_sum = overflow_sum + 32'd1;
                    call_dropped = 1'b1;
                end
                in_call = !op.last;
                if (op.last) call_dropped = 1'b0;
            end
            ACT_CONSUME: begin
                if (op.count >= fill_len) begin
                    fill_len = '0;
                    head_ptr = '0;
                    batch_calls = '0;
                end else begin
                    head_ptr = head_ptr + op.count[13:0];
                    fill_len = fill_len - op.count;
                end
                drains_sum = drains_sum + 64'd1;
            end
            ACT_READ: begin
                if ({1'b0, op.offset} < fill_len) begin
                    slot = head_ptr + op.offset;
                    r.read_data = byte_mem[slot];
                    r.read_in_range = 1'b1;
                end
            end
            default: ;
        endcase
        r.pending_length    = fill_len;
        r.pressure          = (fill_len >= hw_level);
        r.ready_res         = (fill_len != 0);
        r.calls_since_drain = batch_calls;
        r.lifetime_bytes    = bytes_sum;
        r.total_calls       = calls_sum;
        r.drain_count       = drains_sum;
        r.overflow_count    = overflow_sum;
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(input logic [1:0] action, input logic [7:0] byte_val,
                             input logic last, input logic [14:0] count,
                             input logic [13:0] offset);
        buf_op_t op;
        op.action   = action;
        op.byte_val = byte_val;
        op.last     = last;
        op.count    = count;
        op.offset   = offset;
        while ($urandom_range(99) < src_idle) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {3'b000, offset, count, byte_val};
        s_axis_tuser  = action;
        s_axis_tlast  = last;
        do @(posedge i_clk); while (!s_axis_tready);
        status_q.push_back(predict_status(op));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (status_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_high_water(input logic [14:0] value);
        wait_drained();
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        hw_level = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // receiver back-pressure
    always @(negedge i_clk) m_axis_tready = ($urandom_range(99) >= sink_stall);

    always @(posedge i_clk) begin
        buf_status_t got;
        buf_status_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[RES_W-1:0];
            if (status_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result word with none pending: %0h", got);
            end else begin
                want = status_q.pop_front();
                check_field("accepted", want.accepted, got.accepted);
                check_field("read_data", want.read_data, got.read_data);
                check_field("read_in_range", want.read_in_range, got.read_in_range);
                check_field("pending_length", want.pending_length, got.pending_length);
                check_field("pressure", want.pressure, got.pressure);
                check_field("ready_res", want.ready_res, got.ready_res);
                check_field("calls_since_drain", want.calls_since_drain,
                            got.calls_since_drain);
                check_field("lifetime_bytes", want.lifetime_bytes, got.lifetime_bytes);
                check_field("total_calls", want.total_calls, got.total_calls);
                check_field("drain_count", want.drain_count, got.drain_count);
                check_field("overflow_count", want.overflow_count, got.overflow_count);
            end
        end
    end

    task automatic test_empty_buffer();
        send_word(ACT_NOP, 8'h00, 1'b0, 15'd0, 14'd0);
        send_word(ACT_READ, 8'h00, 1'b0, 15'd0, 14'd0);
        send_word(ACT_CONSUME, 8'h00, 1'b0, 15'd0, 14'd0);
    endtask

    task automatic test_calls_and_reads();
        write_high_water(15'd2);
        send_word(ACT_APPEND, 8'h00, 1'b0, 15'd0, 14'd0);
        send_word(ACT_APPEND, 8'hFF, 1'b0, 15'd0, 14'd0);
        send_word(ACT_APPEND, 8'hA5, 1'b1, 15'd0, 14'd0);
        send_word(ACT_APPEND, 8'h5A, 1'b1, 15'd0, 14'd0);
        send_word(ACT_READ, 8'h00, 1'b0, 15'd0, 14'd0);
        send_word(ACT_READ, 8'h00, 1'b0, 15'd0, 14'd3);
        send_word(ACT_READ, 8'h00, 1'b0, 15'd0, 14'd4);
        send_word(ACT_READ, 8'h00, 1'b0, 15'd0, 14'h3FFF);
        send_word(ACT_CONSUME, 8'h00, 1'b0, 15'd1, 14'd0);
        send_word(ACT_READ, 8'h00, 1'b0, 15'd0, 14'd0);
        // consume in the middle of a call leaves the call open
        send_word(ACT_APPEND, 8'h11, 1'b0, 15'd0, 14'd0);
        send_word(ACT_CONSUME, 8'h00, 1'b0, 15'd2, 14'd0);
        send_word(ACT_APPEND, 8'h22, 1'b1, 15'd0, 14'd0);
        send_word(ACT_READ, 8'h00, 1'b0, 15'd0, 14'd1);
        send_word(ACT_CONSUME, 8'h00, 1'b0, 15'h7FFF, 14'd0);
        send_word(ACT_NOP, 8'hFF, 1'b1, 15'h7FFF, 14'h3FFF);
        send_word(ACT_READ, 8'h00, 1'b0, 15'd0, 14'd0);
        send_word(ACT_APPEND, 8'h3C, 1'b0, 15'd0, 14'd0);
        send_word(ACT_CONSUME, 8'h00, 1'b0, 15'd0, 14'd0);
        send_word(ACT_APPEND, 8'hC3, 1'b1, 15'd0, 14'd0);
    endtask

    task automatic test_random_traffic();
        int src_set[4]  = '{0, 80, 0, 14};
        int sink_set[4] = '{0, 0, 80, 14};
        int sent;
        int pick;
        int n;
        for (int p = 0; p < 4; p++) begin
            write_high_water((p == 0) ? 15'($urandom) : 15'($urandom_range(1, 48)));
            src_idle   = src_set[p];
            sink_stall = sink_set[p];
            sent = 0;
            while (sent < 200) begin
                pick = $urandom_range(99);
                if (pick < 45) begin
                    n = $urandom_range(1, 8);
                    for (int k = 0; k < n; k++) begin
                        // now and then a consume or read lands inside the call
                        if (k != 0 && $urandom_range(9) == 0) begin
                            send_word($urandom_range(1) ? ACT_CONSUME : ACT_READ, 8'($urandom),
                                      1'($urandom), 15'($urandom_range(0, 3)),
                                      14'($urandom_range(0, 3)));
                            sent++;
                        end
                        send_word(ACT_APPEND, 8'($urandom), k == n - 1, 15'($urandom),
                                  14'($urandom));
                    end
                    sent += n;
                end else if (pick < 62) begin
                    if ($urandom_range(9) == 0)
                        send_word(ACT_CONSUME, 8'($urandom), 1'($urandom), 15'($urandom),
                                  14'($urandom));
                    else
                        send_word(ACT_CONSUME, 8'($urandom), 1'($urandom),
                                  15'($urandom_range(0, fill_len + 2)), 14'($urandom));
                    sent++;
                end else if (pick < 88) begin
                    if ($urandom_range(9) == 0)
                        send_word(ACT_READ, 8'($urandom), 1'($urandom), 15'($urandom),
                                  14'($urandom));
                    else
                        send_word(ACT_READ, 8'($urandom), 1'($urandom), 15'($urandom),
                                  14'($urandom_range(0, fill_len + 1)));
                    sent++;
                end else if (pick < 93) begin
                    send_word(ACT_NOP, 8'($urandom), 1'($urandom), 15'($urandom),
                              14'($urandom));
                    sent++;
                end else begin
                    // stray word with any action and flag
                    send_word(2'($urandom), 8'($urandom), 1'($urandom),
                              15'($urandom_range(0, fill_len + 2)), 14'($urandom));
                    sent++;
                end
            end
        end
        src_idle   = 0;
        sink_stall = 0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_APPEND;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        head_ptr      = '0;
        fill_len      = '0;
        in_call       = 1'b0;
        call_dropped  = 1'b0;
        batch_calls   = '0;
        bytes_sum     = '0;
        calls_sum     = '0;
        drains_sum    = '0;
        overflow_sum  = '0;
        hw_level      = HIGH_WATER_RESET;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_empty_buffer();
        test_calls_and_reads();
        test_random_traffic();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && status_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #200_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
sv/obwb_pkg.sv
sv/obwb_ram.sv
sv/obwb_ctrl.sv
sv/obwb_dp.sv
sv/output_write_batch_buffer_unit.sv
test/output_write_batch_buffer_unit_test.sv
